@@ hw/rtl/rsem_pkg.sv @@
`default_nettype none
package rsem_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int SUM_W = 41;

    localparam int QUO_W = COUNT_BITS + 2 * FRAC_BITS;
    localparam int SQ_W = QUO_W + (QUO_W % 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int SQREM_W = ROOT_W + 2;
    localparam int WEIGHT_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(QUO_W);

    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_GENES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE = CFG_IDX_W'(1);

    localparam logic [COUNT_BITS-1:0] TOTAL_GENES_RST = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] SET_SIZE_RST = COUNT_BITS'(1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_STORE,
        ST_READY
    } state_t;

    typedef struct packed {
        logic div_load;
        logic div_step;
        logic sq_load;
        logic sq_step;
        logic store_hit;
        logic store_miss;
        logic store_bad;
        logic sel_miss;
        logic accept;
    } cmd_t;

    typedef struct packed {
        logic bad_cfg;
        logic first_pending;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/rsem_ctrl.sv @@
`default_nettype none
module rsem_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write,
    input  wire logic            in_valid,
    input  wire logic            in_last,
    input  wire rsem_pkg::status_t status,
    output rsem_pkg::cmd_t       cmd,
    output logic                 in_ready,
    output logic                 weights_ready
);
    import rsem_pkg::*;

    state_t           state_reg, state_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel_miss = phase_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next = '0;
                if (status.bad_cfg)
                begin
                    cmd.store_bad = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_READY;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_SQ_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SQ_LOAD:
            begin
                cmd.sq_load = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_STORE:
            begin
                cmd.store_hit  = !phase_reg;
                cmd.store_miss = phase_reg;
                if (phase_reg)
                begin
                    phase_next = 1'b0;
                    state_next = ST_READY;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_READY:
            begin
                state_next = ST_READY;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // new register values invalidate the weights
        if (cfg_write)
        begin
            state_next = ST_LOAD;
            phase_next = 1'b0;
            cnt_next   = '0;
        end

        weights_ready = (state_reg == ST_READY);
        in_ready = (!status.first_pending || weights_ready) &&
                   (!in_last || !status.out_full);
        cmd.accept = in_valid && in_ready;
    end

endmodule
`default_nettype wire

@@ hw/rtl/rsem_dp.sv @@
`default_nettype none
module rsem_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rsem_pkg::cmd_t                       cmd,
    input  wire logic                                 cfg_write,
    input  wire logic [rsem_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rsem_pkg::COUNT_BITS-1:0]      cfg_data,
    input  wire logic                                 in_set,
    input  wire logic                                 in_last,
    input  wire logic                                 out_ready,
    output rsem_pkg::status_t                         status,
    output logic                                      out_valid,
    output logic signed [rsem_pkg::SUM_W-1:0]         out_score,
    output logic                                      out_bad
);
    import rsem_pkg::*;

    // configuration registers
    logic [COUNT_BITS-1:0] total_genes_reg;
    logic [COUNT_BITS-1:0] set_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_genes_reg <= TOTAL_GENES_RST;
            set_size_reg    <= SET_SIZE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TOTAL_GENES: total_genes_reg <= cfg_data;
                REG_SET_SIZE:    set_size_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic                  bad_cfg;
    logic [COUNT_BITS-1:0] diff;
    logic [COUNT_BITS-1:0] num;
    logic [COUNT_BITS-1:0] den;

    assign bad_cfg = (set_size_reg == '0) || (set_size_reg >= total_genes_reg);
    assign diff    = total_genes_reg - set_size_reg;
    assign num     = cmd.sel_miss ? set_size_reg : diff;
    assign den     = cmd.sel_miss ? diff : set_size_reg;

    // restoring divider, one quotient bit a cycle
    logic [QUO_W-1:0]      quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [COUNT_BITS:0]   div_trial;
    logic                  div_fit;

    assign div_trial = {rem_reg, quo_reg[QUO_W-1]};
    assign div_fit   = (div_trial >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= {num, {(2 * FRAC_BITS){1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], div_fit};
            rem_reg <= div_fit ? COUNT_BITS'(div_trial - {1'b0, den_reg})
                               : div_trial[COUNT_BITS-1:0];
        end
    end

    // digit-by-digit square root, one root bit a cycle
    logic [SQ_W-1:0]      sq_x_reg;
    logic [SQREM_W-1:0]   sq_rem_reg;
    logic [ROOT_W-1:0]    sq_root_reg;
    logic [SQREM_W+1:0]   sq_shift;
    logic [SQREM_W+1:0]   sq_trial;
    logic                 sq_fit;

    assign sq_shift = {sq_rem_reg, sq_x_reg[SQ_W-1 -: 2]};
    assign sq_trial = (SQREM_W + 2)'({sq_root_reg, 2'b01});
    assign sq_fit   = (sq_shift >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            sq_x_reg    <= SQ_W'(quo_reg);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_x_reg    <= {sq_x_reg[SQ_W-3:0], 2'b00};
            sq_rem_reg  <= sq_fit ? SQREM_W'(sq_shift - sq_trial) : SQREM_W'(sq_shift);
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_fit};
        end
    end

    // weights for the next run
    logic signed [WEIGHT_W-1:0] calc_hit_reg;
    logic signed [WEIGHT_W-1:0] calc_miss_reg;
    logic                       calc_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_hit_reg  <= '0;
            calc_miss_reg <= '0;
            calc_bad_reg  <= 1'b0;
        end
        else if (cmd.store_bad)
        begin
            calc_hit_reg  <= '0;
            calc_miss_reg <= '0;
            calc_bad_reg  <= 1'b1;
        end
        else if (cmd.store_hit)
        begin
            calc_hit_reg <= $signed({1'b0, sq_root_reg});
            calc_bad_reg <= 1'b0;
        end
        else if (cmd.store_miss)
        begin
            calc_miss_reg <= -$signed({1'b0, sq_root_reg});
        end
    end

    // run state
    logic signed [SUM_W-1:0]    running_sum_reg, running_sum_next;
    logic signed [SUM_W-1:0]    best_sum_reg, best_sum_next;
    logic                       first_pending_reg, first_pending_next;
    logic signed [WEIGHT_W-1:0] hit_weight_reg;
    logic signed [WEIGHT_W-1:0] miss_weight_reg;
    logic                       bad_latched_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]    out_score_reg;
    logic                       out_bad_reg;

    logic signed [WEIGHT_W-1:0] use_hit;
    logic signed [WEIGHT_W-1:0] use_miss;
    logic                       use_bad;
    logic signed [WEIGHT_W-1:0] add_w;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;

    always_comb
    begin
        use_hit  = first_pending_reg ? calc_hit_reg : hit_weight_reg;
        use_miss = first_pending_reg ? calc_miss_reg : miss_weight_reg;
        use_bad  = first_pending_reg ? calc_bad_reg : bad_latched_reg;
        add_w    = in_set ? use_hit : use_miss;
        sum_wide = (SUM_W + 1)'(running_sum_reg) + (SUM_W + 1)'(add_w);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        running_sum_next   = running_sum_reg;
        best_sum_next      = best_sum_reg;
        first_pending_next = first_pending_reg;
        out_valid_next     = out_valid_reg && !out_ready;

        if (cmd.accept)
        begin
            running_sum_next = sum_sat;
            if (first_pending_reg || (sum_sat > best_sum_reg))
            begin
                best_sum_next = sum_sat;
            end
            first_pending_next = 1'b0;
            if (in_last)
            begin
                out_valid_next     = 1'b1;
                running_sum_next   = '0;
                first_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= '0;
            best_sum_reg      <= '0;
            first_pending_reg <= 1'b1;
            hit_weight_reg    <= '0;
            miss_weight_reg   <= '0;
            bad_latched_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            running_sum_reg   <= running_sum_next;
            best_sum_reg      <= (cmd.accept && in_last) ? '0 : best_sum_next;
            first_pending_reg <= first_pending_next;
            out_valid_reg     <= out_valid_next;
            if (cmd.accept && first_pending_reg)
            begin
                hit_weight_reg  <= calc_hit_reg;
                miss_weight_reg <= calc_miss_reg;
                bad_latched_reg <= calc_bad_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_last)
        begin
            out_score_reg <= use_bad ? '0 : best_sum_next;
            out_bad_reg   <= use_bad;
        end
    end

    assign status.bad_cfg       = bad_cfg;
    assign status.first_pending = first_pending_reg;
    assign status.out_full      = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_score = out_score_reg;
    assign out_bad   = out_bad_reg;

endmodule
`default_nettype wire

@@ hw/rtl/running_sum_enrichment_max_top.sv @@
// result: registered on m_tdata in the cycle after the transaction of the last gene
// throughput: one gene per cycle in a run; a full output register stalls the last gene
// weights: after reset and after each register write the divider and root unit run
// for the hit weight and then for the miss weight; invalid settings skip them
// a run's first gene waits for the weights
// reset: asynchronous, clears the run state and loads total_genes = 2, set_size = 1
`default_nettype none
module running_sum_enrichment_max_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [rsem_pkg::IN_DATA_W-1:0]        s_tdata,   // in_set
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [rsem_pkg::OUT_DATA_W-1:0]            m_tdata,   // max_score
    output logic [0:0]                                 m_tuser,   // bad_config
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rsem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rsem_pkg::COUNT_BITS-1:0]       cfg_data
);
    import rsem_pkg::*;

    cmd_t                    cmd;
    status_t                 status;
    logic                    cfg_write;
    logic                    weights_ready;
    logic signed [SUM_W-1:0] out_score;
    logic                    out_bad;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    rsem_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .in_valid      (s_tvalid),
        .in_last       (s_tlast),
        .status        (status),
        .cmd           (cmd),
        .in_ready      (s_tready),
        .weights_ready (weights_ready)
    );

    rsem_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_set    (s_tdata[0]),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .status    (status),
        .out_valid (m_tvalid),
        .out_score (out_score),
        .out_bad   (out_bad)
    );

    assign m_tdata = OUT_DATA_W'($unsigned(out_score));
    assign m_tuser = out_bad;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("result missing after last transaction");

    a_bad_scores_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> out_score == '0)
        else $error("bad configuration result carries a nonzero score");

    a_first_waits_weights: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && status.first_pending |-> weights_ready)
        else $error("run started before weights were ready");

endmodule
`default_nettype wire

@@ sim/rsem_score_check.sv @@
module rsem_score_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [rsem_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [rsem_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rsem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsem_pkg::COUNT_BITS-1:0]     cfg_data,
    output int                                  errors,
    output int                                  pending
);
    import rsem_pkg::*;

    localparam int ROOT_MSB = 40;

    typedef struct {
        logic signed [SUM_W-1:0] score;
        logic                    bad;
    } score_t;

    score_t score_q[$];

    logic [COUNT_BITS-1:0]       genes_total;
    logic [COUNT_BITS-1:0]       set_total;
    logic signed [SUM_W-1:0]     run_sum;
    logic signed [SUM_W-1:0]     peak_sum;
    logic                        run_fresh;
    logic signed [WEIGHT_W-1:0]  hit_w;
    logic signed [WEIGHT_W-1:0]  miss_w;
    logic                        run_bad;
    int                          bad_results;

    // floor(sqrt(num / den) * 2^FRAC_BITS), bit by bit
    function automatic logic [WEIGHT_W-1:0] q_root(logic [COUNT_BITS-1:0] num,
                                                   logic [COUNT_BITS-1:0] den);
        logic [127:0] target;
        logic [127:0] root;
        logic [127:0] cand;
        target = 128'(num) << (2 * FRAC_BITS);
        root = '0;
        for (int i = ROOT_MSB; i >= 0; i--)
        begin
            cand = root | (128'(1) << i);
            if (cand * cand * 128'(den) <= target)
                root = cand;
        end
        return WEIGHT_W'(root);
    endfunction

    function automatic logic signed [SUM_W-1:0] add_clamped(logic signed [SUM_W-1:0] acc,
                                                            logic signed [WEIGHT_W-1:0] w);
        longint total;
        total = longint'(acc) + longint'(w);
        if (total > longint'(SUM_MAX))
            return SUM_MAX;
        if (total < longint'(SUM_MIN))
            return SUM_MIN;
        return SUM_W'(total);
    endfunction

    task automatic clear_run();
        run_sum = '0;
        peak_sum = '0;
        run_fresh = 1'b1;
        hit_w = '0;
        miss_w = '0;
        run_bad = 1'b0;
    endtask

    task automatic score_gene(logic hit, logic fin);
        score_t res;
        if (run_fresh)
        begin
            if (set_total == '0 || set_total >= genes_total)
            begin
                run_bad = 1'b1;
                hit_w = '0;
                miss_w = '0;
            end
            else
            begin
                run_bad = 1'b0;
                hit_w = $signed(q_root(genes_total - set_total, set_total));
                miss_w = -$signed(q_root(set_total, genes_total - set_total));
            end
        end
        run_sum = add_clamped(run_sum, hit ? hit_w : miss_w);
        if (run_fresh || run_sum > peak_sum)
            peak_sum = run_sum;
        run_fresh = 1'b0;
        if (fin)
        begin
            res.score = run_bad ? '0 : peak_sum;
            res.bad = run_bad;
            score_q.insert(score_q.size(), res);
            clear_run();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        score_t want;
        if (!rst_n)
        begin
            genes_total = TOTAL_GENES_RST;
            set_total = SET_SIZE_RST;
            clear_run();
            score_q.delete();
            bad_results = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (score_q.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result transaction: max_score %0d bad_config %0b",
                                 $signed(m_tdata[SUM_W-1:0]), m_tuser[0]);
                end
                else
                begin
                    want = score_q.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.score || m_tuser[0] !== want.bad)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"result mismatch: expected max_score %0d ",
                                      "bad_config %0b, got max_score %0d bad_config %0b"},
                                     want.score, want.bad,
                                     $signed(m_tdata[SUM_W-1:0]), m_tuser[0]);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOTAL_GENES: genes_total = cfg_data;
                    REG_SET_SIZE:    set_total = cfg_data;
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                score_gene(s_tdata[0], s_tlast);
            errors <= bad_results;
            pending <= score_q.size();
        end
    end

endmodule

@@ sim/running_sum_enrichment_max_top_tb.sv @@
module running_sum_enrichment_max_top_tb;

    import rsem_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam int GENE_TARGET = 800;
    localparam int HOLD_CYCLES = 400;
    localparam int FLOOD_RUNS = 40;
    localparam int LONG_RUN = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_TIME = 12000000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [0:0]              m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [COUNT_BITS-1:0]   cfg_data = '0;

    int errors;
    int pending;
    int genes_sent = 0;
    int s_calm = 0;
    int r_calm = 0;
    bit hold_req = 1'b0;
    bit flooded = 1'b0;

    always #10 clk = ~clk;

    running_sum_enrichment_max_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsem_score_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // idle cycles before the next transaction, with occasional gap-free stretches
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 18);
    endfunction

    task automatic send_gene(input bit hit, input bit fin, input bit quick);
        int gap;
        gap = quick ? 0 : draw_wait(s_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'(hit);
        s_tlast <= fin;
        do @(posedge clk); while (!s_tready);
        genes_sent++;
    endtask

    task automatic send_run(input int len, input int hit_pct, input bit quick, input bit close);
        for (int k = 0; k < len; k++)
            send_gene($urandom_range(0, 99) < hit_pct, close && (k == len - 1), quick);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_genes(input int n, input int g, input bit spare);
        if (spare)
        begin
            write_reg(REG_SPARE_LO, COUNT_BITS'($urandom));
            write_reg(REG_SPARE_HI, COUNT_BITS'($urandom));
        end
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_TOTAL_GENES, COUNT_BITS'(n));
            write_reg(REG_SET_SIZE, COUNT_BITS'(g));
        end
        else
        begin
            write_reg(REG_SET_SIZE, COUNT_BITS'(g));
            write_reg(REG_TOTAL_GENES, COUNT_BITS'(n));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        int n;
        int g;
        case ($urandom_range(0, 7))
            0:       n = 2;
            1:       n = 65535;
            2:       n = $urandom_range(0, 1);
            3:       n = $urandom_range(2, 64);
            default: n = $urandom_range(2, 65535);
        endcase
        case ($urandom_range(0, 9))
            0:       g = 1;
            1:       g = n - 1;
            2:       g = 0;
            3:       g = n;
            4:       g = n + $urandom_range(1, 65535);
            5:       g = $urandom_range(0, 65535);
            default: g = (n >= 2) ? $urandom_range(1, n - 1) : 1;
        endcase
        set_genes(n, g, $urandom_range(0, 7) == 0);
    endtask

    // result side: random stalls, plus one long hold when asked
    initial
    begin
        int stall;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = draw_wait(r_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        #LIMIT_TIME;
        $display("running_sum_enrichment_max_top_tb: errors");
        $finish;
    end

    initial
    begin
        int nruns;
        int len;
        int pct;
        int cut;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, single-gene runs both ways, then a two-gene run
        send_gene(1'b1, 1'b1, 1'b0);
        send_gene(1'b0, 1'b1, 1'b0);
        send_gene(1'b0, 1'b0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);
        // largest hit weight
        settle();
        set_genes(65535, 1, 1'b0);
        send_gene(1'b1, 1'b0, 1'b0);
        send_gene(1'b0, 1'b0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);
        // largest miss weight
        settle();
        set_genes(65535, 65534, 1'b0);
        send_gene(1'b0, 1'b0, 1'b0);
        send_gene(1'b0, 1'b0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);
        // invalid settings: set equal to list, empty set, set above list
        settle();
        set_genes(65535, 65535, 1'b0);
        send_gene(1'b1, 1'b0, 1'b0);
        send_gene(1'b0, 1'b1, 1'b0);
        settle();
        set_genes(40, 0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);
        settle();
        set_genes(2, 65535, 1'b0);
        send_gene(1'b0, 1'b1, 1'b0);
        // register change inside a run keeps the latched weights
        settle();
        set_genes(10, 3, 1'b1);
        send_gene(1'b1, 1'b0, 1'b0);
        send_gene(1'b0, 1'b0, 1'b0);
        settle();
        write_reg(REG_SET_SIZE, COUNT_BITS'(9));
        cfg_valid <= 1'b0;
        send_gene(1'b1, 1'b0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);
        send_gene(1'b0, 1'b1, 1'b0);
        // run longer than the list
        settle();
        set_genes(2, 1, 1'b0);
        send_run(5, 0, 1'b0, 1'b0);
        send_gene(1'b1, 1'b1, 1'b0);

        while (genes_sent < GENE_TARGET)
        begin
            settle();
            random_config();
            nruns = $urandom_range(1, 6);
            for (int r = 0; r < nruns; r++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60)
                                                  : $urandom_range(1, 10);
                pct = 25 * $urandom_range(0, 4);
                if (len > 1 && $urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, len - 1);
                    send_run(cut, pct, 1'b0, 1'b0);
                    settle();
                    write_reg($urandom_range(0, 1) ? REG_TOTAL_GENES : REG_SET_SIZE,
                              COUNT_BITS'($urandom));
                    cfg_valid <= 1'b0;
                    send_run(len - cut, pct, 1'b0, 1'b1);
                end
                else
                    send_run(len, pct, 1'b0, 1'b1);
            end
            // back-to-back short runs while the result side holds off
            if (!flooded && genes_sent > 300)
            begin
                flooded = 1'b1;
                hold_req = 1'b1;
                for (int r = 0; r < FLOOD_RUNS; r++)
                    send_run($urandom_range(1, 2), 50, 1'b1, 1'b1);
            end
        end

        // long gap-free run at the largest hit weight
        settle();
        set_genes(65535, 1, 1'b0);
        send_run(LONG_RUN, 100, 1'b1, 1'b0);
        send_gene(1'b0, 1'b0, 1'b1);
        send_gene(1'b0, 1'b1, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("running_sum_enrichment_max_top_tb: clean");
        else
            $display("running_sum_enrichment_max_top_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rsem_pkg.sv
hw/rtl/rsem_ctrl.sv
hw/rtl/rsem_dp.sv
hw/rtl/running_sum_enrichment_max_top.sv
sim/rsem_score_check.sv
sim/running_sum_enrichment_max_top_tb.sv
